// File: hdl/htd_pkg.sv
// ----------------------------------------------------------------------------
// htd_pkg
// Shared sizes, record types and the bucket hash of the hashed trie dictionary.
// ----------------------------------------------------------------------------
package htd_pkg;

  localparam int MAX_NODES = 256;
  // bucket index is the low bits of the hash sum, so buckets are a power of two
  localparam int BUCKETS   = 256;
  localparam int LETTER_W  = 8;
  localparam int NODE_W    = $clog2(MAX_NODES);
  localparam int CNT_W     = $clog2(MAX_NODES + 1);
  localparam int BUCKET_W  = $clog2(BUCKETS);
  localparam int HSUM_W    = ((NODE_W > LETTER_W) ? NODE_W : LETTER_W) + 6;

  typedef logic [NODE_W-1:0]   node_t;
  typedef logic [BUCKET_W-1:0] bucket_t;
  typedef logic [LETTER_W-1:0] letter_t;
  typedef logic [CNT_W-1:0]    cnt_t;

  // one transition, stored at the index of its target node
  typedef struct packed {
    node_t   src;
    letter_t letter;
    node_t   next;
  } edge_t;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic head_rd;
    logic head_cap;
    logic edge_rd_head;
    logic edge_rd_next;
    logic hit;
    logic set_failed;
    logic set_ovf;
    logic create;
    logic final_rd;
    logic mark;
    logic finish;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic skip;
    logic aborted;
    logic head_empty;
    logic edge_match;
    logic next_zero;
    logic full;
    logic is_query;
    logic is_last;
    logic at_root;
  } sts_t;

  function automatic bucket_t bucket_of(input letter_t letter, input node_t node);
    logic [HSUM_W-1:0] sum;
    sum = HSUM_W'(letter) * HSUM_W'(31) + HSUM_W'(node) * HSUM_W'(17);
    return sum[BUCKET_W-1:0];
  endfunction

endpackage

// File: hdl/htd_ram.sv
// ----------------------------------------------------------------------------
// htd_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module htd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// File: hdl/htd_ctrl.sv
// ----------------------------------------------------------------------------
// htd_ctrl
// Sequencer for one word: hash, bucket head read, chain walk, node creation
// and the end-of-word final mark handling.
// ----------------------------------------------------------------------------
module htd_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  output logic          busy,
  input  htd_pkg::sts_t sts,
  output htd_pkg::cmd_t cmd
);
  import htd_pkg::*;

  typedef enum logic [6:0] {
    S_IDLE   = 7'b0000001,
    S_HASH   = 7'b0000010,
    S_HEAD   = 7'b0000100,
    S_EDGE   = 7'b0001000,
    S_CREATE = 7'b0010000,
    S_FIN    = 7'b0100000,
    S_FRD    = 7'b1000000
  } state_t;

  state_t state_r, state_nxt;
  state_t after_letter;
  state_t miss_state;

  assign after_letter = sts.is_last ? S_FIN : S_IDLE;

  // no transition found for this letter
  always_comb begin
    if (sts.is_query || sts.full) begin
      miss_state = after_letter;
    end else begin
      miss_state = S_CREATE;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.load  = 1'b1;
          state_nxt = S_HASH;
        end
      end
      S_HASH: begin
        if (sts.skip) begin
          state_nxt = after_letter;
        end else begin
          cmd.head_rd = 1'b1;
          state_nxt   = S_HEAD;
        end
      end
      S_HEAD: begin
        cmd.head_cap = 1'b1;
        if (sts.head_empty) begin
          cmd.set_failed = sts.is_query;
          cmd.set_ovf    = !sts.is_query && sts.full;
          state_nxt      = miss_state;
        end else begin
          cmd.edge_rd_head = 1'b1;
          state_nxt        = S_EDGE;
        end
      end
      S_EDGE: begin
        if (sts.edge_match) begin
          cmd.hit   = 1'b1;
          state_nxt = after_letter;
        end else if (sts.next_zero) begin
          cmd.set_failed = sts.is_query;
          cmd.set_ovf    = !sts.is_query && sts.full;
          state_nxt      = miss_state;
        end else begin
          cmd.edge_rd_next = 1'b1;
        end
      end
      S_CREATE: begin
        cmd.create = 1'b1;
        state_nxt  = after_letter;
      end
      S_FIN: begin
        if (sts.is_query && !sts.aborted && !sts.at_root) begin
          cmd.final_rd = 1'b1;
          state_nxt    = S_FRD;
        end else begin
          cmd.mark   = !sts.is_query && !sts.aborted;
          cmd.finish = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      S_FRD: begin
        cmd.finish = 1'b1;
        state_nxt  = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy = (state_r != S_IDLE);

endmodule

// File: hdl/htd_dp.sv
// ----------------------------------------------------------------------------
// htd_dp
// Datapath: word walk registers, bucket head table, transition store,
// final marks and the result register.
// ----------------------------------------------------------------------------
module htd_dp (
  input  logic             clk,
  input  logic             rst_n,
  input  htd_pkg::cmd_t    cmd,
  output htd_pkg::sts_t    sts,
  input  logic             in_kind,
  input  htd_pkg::letter_t in_letter,
  input  logic             in_no_letter,
  input  logic             in_last,
  output logic             out_valid,
  output logic             out_found,
  output logic             out_status
);
  import htd_pkg::*;

  logic    kind_r, no_letter_r, last_r;
  letter_t letter_r;
  node_t   cur_r, cur_nxt;
  cnt_t    free_r;
  logic    failed_r, ovf_r;
  bucket_t bucket_r, bucket_c;
  node_t   head_link_r, head_link_c, link_r, edge_raddr;
  logic    root_final_r;
  logic    head_vld_q;
  logic [BUCKETS-1:0] head_vld_r;
  logic    out_valid_r, out_found_r, out_status_r;
  node_t   fresh;
  node_t   head_rdata;
  edge_t   edge_rdata, edge_wdata;
  logic    fin_rdata, fin_we, fin_wdata;
  node_t   fin_waddr;
  logic    found_c;

  assign bucket_c    = bucket_of(letter_r, cur_r);
  assign head_link_c = head_vld_q ? head_rdata : '0;
  assign fresh       = free_r[NODE_W-1:0];
  assign edge_raddr  = cmd.edge_rd_head ? head_link_c : edge_rdata.next;

  assign edge_wdata.src    = cur_r;
  assign edge_wdata.letter = letter_r;
  assign edge_wdata.next   = head_link_r;

  // a new node gets its final mark cleared, so the store needs no reset sweep
  assign fin_we    = cmd.create || (cmd.mark && (cur_r != '0));
  assign fin_waddr = cmd.create ? fresh : cur_r;
  assign fin_wdata = !cmd.create;

  htd_ram #(.WIDTH(NODE_W), .DEPTH(BUCKETS)) u_head_ram (
    .clk   (clk),
    .we    (cmd.create),
    .waddr (bucket_r),
    .wdata (fresh),
    .re    (cmd.head_rd),
    .raddr (bucket_c),
    .rdata (head_rdata)
  );

  htd_ram #(.WIDTH($bits(edge_t)), .DEPTH(MAX_NODES)) u_edge_ram (
    .clk   (clk),
    .we    (cmd.create),
    .waddr (fresh),
    .wdata (edge_wdata),
    .re    (cmd.edge_rd_head || cmd.edge_rd_next),
    .raddr (edge_raddr),
    .rdata (edge_rdata)
  );

  htd_ram #(.WIDTH(1), .DEPTH(MAX_NODES)) u_final_ram (
    .clk   (clk),
    .we    (fin_we),
    .waddr (fin_waddr),
    .wdata (fin_wdata),
    .re    (cmd.final_rd),
    .raddr (cur_r),
    .rdata (fin_rdata)
  );

  assign sts.skip       = no_letter_r || failed_r || ovf_r;
  assign sts.aborted    = failed_r || ovf_r;
  assign sts.head_empty = (head_link_c == '0);
  assign sts.edge_match = (edge_rdata.src == cur_r) && (edge_rdata.letter == letter_r);
  assign sts.next_zero  = (edge_rdata.next == '0);
  assign sts.full       = (free_r >= CNT_W'(MAX_NODES));
  assign sts.is_query   = kind_r;
  assign sts.is_last    = last_r;
  assign sts.at_root    = (cur_r == '0);

  assign found_c = kind_r && !failed_r && !ovf_r &&
                   ((cur_r == '0) ? root_final_r : fin_rdata);

  always_comb begin
    cur_nxt = cur_r;
    if (cmd.finish) begin
      cur_nxt = '0;
    end else if (cmd.create) begin
      cur_nxt = fresh;
    end else if (cmd.hit) begin
      cur_nxt = link_r;
    end
  end

  // item payload and walk scratch
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      kind_r      <= in_kind;
      letter_r    <= in_letter;
      no_letter_r <= in_no_letter;
      last_r      <= in_last;
    end
    if (cmd.head_rd) begin
      bucket_r <= bucket_c;
    end
    if (cmd.head_cap) begin
      head_link_r <= head_link_c;
    end
    if (cmd.edge_rd_head || cmd.edge_rd_next) begin
      link_r <= edge_raddr;
    end
    out_found_r  <= found_c;
    out_status_r <= ovf_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_r        <= '0;
      free_r       <= CNT_W'(1);
      failed_r     <= 1'b0;
      ovf_r        <= 1'b0;
      root_final_r <= 1'b0;
      head_vld_r   <= '0;
      head_vld_q   <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      cur_r       <= cur_nxt;
      out_valid_r <= cmd.finish;
      if (cmd.head_rd) begin
        head_vld_q <= head_vld_r[bucket_c];
      end
      if (cmd.create) begin
        free_r               <= free_r + CNT_W'(1);
        head_vld_r[bucket_r] <= 1'b1;
      end
      if (cmd.mark && (cur_r == '0)) begin
        root_final_r <= 1'b1;
      end
      if (cmd.finish) begin
        failed_r <= 1'b0;
        ovf_r    <= 1'b0;
      end else begin
        if (cmd.set_failed) begin
          failed_r <= 1'b1;
        end
        if (cmd.set_ovf) begin
          ovf_r <= 1'b1;
        end
      end
    end
  end

  assign out_valid  = out_valid_r;
  assign out_found  = out_found_r;
  assign out_status = out_status_r;

endmodule

// File: hdl/hashed_trie_dictionary_top.sv
// ----------------------------------------------------------------------------
// hashed_trie_dictionary_top
// Word dictionary: a trie whose transitions live in a chained hash table.
// ----------------------------------------------------------------------------
// Usage: a word is sent one letter per input word. Raise start with in_kind
// (0 insert, 1 query), in_letter, in_no_letter and in_last; the word is taken
// on a clock edge where start is high and busy is low. An item with
// in_no_letter set skips the lookup (used for the empty word).
// The item with in_last set ends the word: out_valid pulses for a single
// cycle, the first cycle in which busy is low again, with out_found (query
// hit) and out_status (1 when the node store ran full during an insert). The
// receiver cannot stall; the result is simply presented for that one cycle.
// Per letter the controller steps through accept, hash and bucket head read,
// then visits the transition records on the bucket chain, and creates a new
// node on an insert miss while the store has room. A skipped letter goes
// from hash straight on to the next letter or to the end of word. The chain
// walk through the transition store reads one record per cycle. End of word
// adds the final state, and a final mark read for a query ending off the root.
// Reset (rst_n low, synchronous) empties the dictionary at once: bucket heads
// carry valid flops and new nodes clear their final mark, so no sweep runs.
// ----------------------------------------------------------------------------
module hashed_trie_dictionary_top (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  output logic                     busy,
  input  logic                     in_kind,
  input  logic [7:0]               in_letter,
  input  logic                     in_no_letter,
  input  logic                     in_last,
  output logic                     out_valid,
  output logic                     out_found,
  output logic                     out_status
);
  import htd_pkg::*;

  cmd_t cmd;
  sts_t sts;

  htd_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .sts   (sts),
    .cmd   (cmd)
  );

  htd_dp u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .sts          (sts),
    .in_kind      (in_kind),
    .in_letter    (in_letter),
    .in_no_letter (in_no_letter),
    .in_last      (in_last),
    .out_valid    (out_valid),
    .out_found    (out_found),
    .out_status   (out_status)
  );

endmodule

// File: sim/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the hashed trie dictionary. Keys go in one letter
// per word through start/busy. A local trie model predicts found and status
// for every key end, and each strobed result is compared with the oldest
// prediction. Directed keys come first, then random traffic built from known
// keys, then the node store is filled and overflow traffic follows.
// ----------------------------------------------------------------------------
module tb;

  localparam int NODES         = htd_pkg::MAX_NODES;
  localparam int SLOTS         = htd_pkg::BUCKETS;
  localparam int KEY_MAX       = 24;
  localparam int KEYS_MAX      = 400;
  localparam int FRESH_CEILING = 200;
  localparam int IDLE_LIMIT    = 5000;
  localparam int DRAIN_CYCLES  = 30;
  localparam bit KIND_INSERT   = 1'b0;
  localparam bit KIND_QUERY    = 1'b1;

  typedef struct packed {
    htd_pkg::node_t   src;
    htd_pkg::letter_t letter;
    htd_pkg::node_t   link;
  } arc_t;

  typedef struct packed {
    logic found;
    logic status;
  } verdict_t;

  logic       clk          = 1'b0;
  logic       rst_n        = 1'b0;
  logic       start        = 1'b0;
  logic       in_kind      = 1'b0;
  logic [7:0] in_letter    = 8'h00;
  logic       in_no_letter = 1'b0;
  logic       in_last      = 1'b0;
  logic       busy;
  logic       out_valid;
  logic       out_found;
  logic       out_status;

  // trie model
  arc_t             arc_of [NODES];
  htd_pkg::node_t   chain_top [SLOTS];
  bit               accept_mark [NODES];
  htd_pkg::node_t   walk_node;
  int               next_free;
  bit               query_missed;
  bit               store_overflow;
  verdict_t         verdict_q [$];

  // known keys and the key being built
  htd_pkg::letter_t key_letter [KEYS_MAX][KEY_MAX];
  int               key_len [KEYS_MAX];
  int               key_count = 0;
  bit               kbuf_kind [KEY_MAX];
  htd_pkg::letter_t kbuf_letter [KEY_MAX];
  bit               kbuf_nol [KEY_MAX];
  int               kbuf_len = 0;

  int errors      = 0;
  int words_sent  = 0;
  int gap_max     = 0;
  int idle_cycles = 0;

  hashed_trie_dictionary_top uut (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .in_kind      (in_kind),
    .in_letter    (in_letter),
    .in_no_letter (in_no_letter),
    .in_last      (in_last),
    .out_valid    (out_valid),
    .out_found    (out_found),
    .out_status   (out_status)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic void trie_clear();
    int i;
    for (i = 0; i < SLOTS; i++) chain_top[i] = '0;
    for (i = 0; i < NODES; i++) accept_mark[i] = 1'b0;
    walk_node      = '0;
    next_free      = 1;
    query_missed   = 1'b0;
    store_overflow = 1'b0;
  endfunction

  function automatic int hash_slot(input htd_pkg::letter_t l, input htd_pkg::node_t n);
    return (int'(l) * 31 + int'(n) * 17) % SLOTS;
  endfunction

  // advances the model by one word; returns 1 when the word ends a key
  function automatic bit trie_step(input bit k, input htd_pkg::letter_t l, input bit nol,
                                   input bit lst, output bit fnd, output bit sts);
    int             slot;
    htd_pkg::node_t hop;
    htd_pkg::node_t hit_node;
    fnd      = 1'b0;
    sts      = 1'b0;
    hit_node = '0;
    if (!nol && !query_missed && !store_overflow) begin
      slot = hash_slot(l, walk_node);
      hop  = chain_top[slot];
      while (hop != 0 && hit_node == 0) begin
        if (arc_of[hop].src == walk_node && arc_of[hop].letter == l) hit_node = hop;
        else hop = arc_of[hop].link;
      end
      if (hit_node != 0) walk_node = hit_node;
      else if (k == KIND_QUERY) query_missed = 1'b1;
      else if (next_free >= NODES) store_overflow = 1'b1;
      else begin
        arc_of[next_free] = '{src: walk_node, letter: l, link: chain_top[slot]};
        chain_top[slot]   = htd_pkg::node_t'(next_free);
        walk_node         = htd_pkg::node_t'(next_free);
        next_free++;
      end
    end
    if (!lst) return 1'b0;
    sts = store_overflow;
    if (!query_missed && !store_overflow) begin
      if (k == KIND_QUERY) fnd = accept_mark[walk_node];
      else accept_mark[walk_node] = 1'b1;
    end
    walk_node      = '0;
    query_missed   = 1'b0;
    store_overflow = 1'b0;
    return 1'b1;
  endfunction

  function automatic htd_pkg::letter_t pick_letter();
    if ($urandom_range(0, 9) < 3) return htd_pkg::letter_t'($urandom_range(1, 255));
    return htd_pkg::letter_t'(8'h61 + $urandom_range(0, 5));
  endfunction

  function automatic void add_letter(input bit k, input htd_pkg::letter_t l, input bit nol);
    if (kbuf_len < KEY_MAX) begin
      kbuf_kind[kbuf_len]   = k;
      kbuf_letter[kbuf_len] = l;
      kbuf_nol[kbuf_len]    = nol;
      kbuf_len++;
    end
  endfunction

  function automatic void load_key(input int idx, input bit k, input int n);
    int i;
    kbuf_len = 0;
    for (i = 0; i < n; i++) add_letter(k, key_letter[idx][i], 1'b0);
  endfunction

  function automatic void remember_key();
    int i;
    int n;
    n = 0;
    if (key_count < KEYS_MAX) begin
      for (i = 0; i < kbuf_len; i++) begin
        if (!kbuf_nol[i]) begin
          key_letter[key_count][n] = kbuf_letter[i];
          n++;
        end
      end
      if (n != 0) begin
        key_len[key_count] = n;
        key_count++;
      end
    end
  endfunction

  task automatic report_mismatch(input string what, input int want, input int got);
    errors++;
    $display("mismatch at %0t: %s expected %0d got %0d", $time, what, want, got);
  endtask

  // one word through start/busy; start stays high when the next word follows at once
  task automatic send_letter(input bit k, input htd_pkg::letter_t l, input bit nol,
                             input bit lst);
    int gap;
    bit fnd;
    bit sts;
    gap = $urandom_range(0, gap_max);
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start        <= 1'b1;
    in_kind      <= k;
    in_letter    <= l;
    in_no_letter <= nol;
    in_last      <= lst;
    @(posedge clk);
    while (busy) @(posedge clk);
    if (!nol || lst) words_sent++;
    if (trie_step(k, l, nol, lst, fnd, sts)) verdict_q.push_back('{found: fnd, status: sts});
  endtask

  task automatic send_key();
    int i;
    for (i = 0; i < kbuf_len; i++)
      send_letter(kbuf_kind[i], kbuf_letter[i], kbuf_nol[i], i == kbuf_len - 1);
  endtask

  task automatic wait_drained();
    start <= 1'b0;
    @(posedge clk);
    while (verdict_q.size() != 0) @(posedge clk);
  endtask

  task automatic random_traffic(input int target);
    int pick;
    int idx;
    int i;
    int n;
    int keys_done;
    bit k;
    bit fresh_ok;
    keys_done = 0;
    while (words_sent < target) begin
      if ($urandom_range(0, 39) == 0)
        gap_max = ($urandom_range(0, 2) == 0) ? 0 : ($urandom_range(0, 1) ? 4 : 16);
      fresh_ok = next_free < FRESH_CEILING || next_free >= NODES;
      pick     = $urandom_range(0, 99);
      idx      = $urandom_range(0, key_count - 1);
      kbuf_len = 0;
      if (pick < 15 && fresh_ok) begin
        // new key, often grown from a known prefix
        if ($urandom_range(0, 1)) load_key(idx, KIND_INSERT, $urandom_range(1, key_len[idx]));
        n = $urandom_range(1, 3);
        for (i = 0; i < n; i++) add_letter(KIND_INSERT, pick_letter(), 1'b0);
        remember_key();
      end else if (pick < 45) begin
        load_key(idx, KIND_QUERY, key_len[idx]);
      end else if (pick < 60) begin
        // near miss: shortened, altered or extended key
        load_key(idx, KIND_QUERY, key_len[idx]);
        n = $urandom_range(0, 2);
        if (n == 0 && kbuf_len > 1) kbuf_len--;
        else if (n == 1) kbuf_letter[$urandom_range(0, kbuf_len - 1)] = pick_letter();
        else add_letter(KIND_QUERY, pick_letter(), 1'b0);
      end else if (pick < 70) begin
        load_key(idx, KIND_INSERT, $urandom_range(1, key_len[idx]));
      end else if (pick < 80) begin
        load_key(idx, KIND_QUERY, key_len[idx]);
        for (i = 0; i < kbuf_len; i++) kbuf_kind[i] = bit'($urandom_range(0, 1));
        if ($urandom_range(0, 1))
          add_letter(fresh_ok ? bit'($urandom_range(0, 1)) : KIND_QUERY, pick_letter(), 1'b0);
      end else if (pick < 88) begin
        add_letter(bit'($urandom_range(0, 1)), pick_letter(), 1'b1);
      end else begin
        // known key with letterless words mixed in
        k = bit'($urandom_range(0, 1));
        for (i = 0; i < key_len[idx]; i++) begin
          if ($urandom_range(0, 3) == 0) add_letter(k, pick_letter(), 1'b1);
          add_letter(k, key_letter[idx][i], 1'b0);
        end
        if ($urandom_range(0, 2) == 0) add_letter(k, pick_letter(), 1'b1);
      end
      send_key();
      keys_done++;
      if (keys_done % 60 == 0) wait_drained();
    end
  endtask

  task automatic test_empty_key();
    kbuf_len = 0;
    add_letter(KIND_QUERY, 8'h5A, 1'b1);
    send_key();
    kbuf_len = 0;
    add_letter(KIND_INSERT, 8'hA5, 1'b1);
    send_key();
    kbuf_len = 0;
    add_letter(KIND_QUERY, 8'h00, 1'b1);
    send_key();
    wait_drained();
  endtask

  task automatic test_letter_extremes();
    kbuf_len = 0;
    add_letter(KIND_INSERT, 8'h01, 1'b0);
    add_letter(KIND_INSERT, 8'hFF, 1'b0);
    send_key();
    remember_key();
    kbuf_len = 0;
    add_letter(KIND_QUERY, 8'h01, 1'b0);
    add_letter(KIND_QUERY, 8'hFF, 1'b0);
    send_key();
    // prefix of a key, not marked
    kbuf_len = 0;
    add_letter(KIND_QUERY, 8'h01, 1'b0);
    send_key();
    // zero byte is an ordinary letter
    kbuf_len = 0;
    add_letter(KIND_INSERT, 8'h00, 1'b0);
    send_key();
    remember_key();
    kbuf_len = 0;
    add_letter(KIND_QUERY, 8'h00, 1'b0);
    send_key();
    kbuf_len = 0;
    add_letter(KIND_QUERY, 8'h80, 1'b0);
    send_key();
    wait_drained();
  endtask

  task automatic test_odd_sequences();
    // query miss, rest of the key skipped
    kbuf_len = 0;
    add_letter(KIND_QUERY, 8'h02, 1'b0);
    add_letter(KIND_QUERY, 8'h01, 1'b0);
    send_key();
    kbuf_len = 0;
    add_letter(KIND_INSERT, 8'h7E, 1'b0);
    add_letter(KIND_INSERT, 8'h3C, 1'b1);
    add_letter(KIND_INSERT, 8'h7E, 1'b0);
    send_key();
    remember_key();
    kbuf_len = 0;
    add_letter(KIND_QUERY, 8'h7E, 1'b0);
    add_letter(KIND_QUERY, 8'h7E, 1'b0);
    send_key();
    // key closed by a letterless word
    kbuf_len = 0;
    add_letter(KIND_QUERY, 8'h01, 1'b0);
    add_letter(KIND_QUERY, 8'hFF, 1'b0);
    add_letter(KIND_QUERY, 8'hC3, 1'b1);
    send_key();
    // mixed kinds: insert then query ending
    kbuf_len = 0;
    add_letter(KIND_INSERT, 8'h55, 1'b0);
    add_letter(KIND_QUERY, 8'h55, 1'b0);
    send_key();
    // query miss then insert ending marks nothing
    kbuf_len = 0;
    add_letter(KIND_QUERY, 8'h33, 1'b0);
    add_letter(KIND_INSERT, 8'h33, 1'b0);
    send_key();
    kbuf_len = 0;
    add_letter(KIND_QUERY, 8'h33, 1'b0);
    send_key();
    wait_drained();
  endtask

  task automatic test_random_keys();
    gap_max = 8;
    random_traffic(950);
    wait_drained();
  endtask

  task automatic test_store_full();
    int i;
    int n;
    gap_max = 2;
    while (next_free < NODES) begin
      kbuf_len = 0;
      for (i = 0; i < 8; i++)
        add_letter(KIND_INSERT, htd_pkg::letter_t'($urandom_range(1, 255)), 1'b0);
      send_key();
      remember_key();
    end
    // new keys now overflow; the last one ends in a query
    for (n = 0; n < 3; n++) begin
      kbuf_len = 0;
      for (i = 0; i < 4; i++)
        add_letter((n == 2 && i == 3) ? KIND_QUERY : KIND_INSERT,
                   htd_pkg::letter_t'($urandom_range(1, 255)), 1'b0);
      send_key();
    end
    wait_drained();
    random_traffic(1350);
    wait_drained();
  endtask

  always @(posedge clk) begin
    verdict_t want;
    if (rst_n && out_valid) begin
      if (verdict_q.size() == 0) report_mismatch("unexpected result", 0, 1);
      else begin
        want = verdict_q.pop_front();
        if (out_found !== want.found) report_mismatch("found", want.found, out_found);
        if (out_status !== want.status) report_mismatch("status", want.status, out_status);
      end
    end
  end

  // nothing moving for too long means a hang
  always @(posedge clk) begin
    if ((start && !busy) || out_valid) idle_cycles <= 0;
    else if (idle_cycles >= IDLE_LIMIT) begin
      $display("tb NOT OK");
      $finish;
    end else idle_cycles <= idle_cycles + 1;
  end

  initial begin
    trie_clear();
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    gap_max = 4;
    test_empty_key();
    test_letter_extremes();
    test_odd_sequences();
    test_random_keys();
    test_store_full();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) $display("tb OK");
    else $display("tb NOT OK");
    $finish;
  end

endmodule

// File: sim.f
hdl/htd_pkg.sv
hdl/htd_ram.sv
hdl/htd_ctrl.sv
hdl/htd_dp.sv
hdl/hashed_trie_dictionary_top.sv
sim/tb.sv
